### rtl/core/assert_macros.svh
// Assertion macros for the checker file ted_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TED_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ted_pkg.sv
package ted_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ted_in_t;

  typedef struct packed {
    logic [2:0] encoding_class;
    logic [1:0] bom_length;
  } ted_out_t;

  localparam logic [2:0] CLS_NONE        = 3'd0;
  localparam logic [2:0] CLS_ASCII       = 3'd1;
  localparam logic [2:0] CLS_UTF8_BOM    = 3'd2;
  localparam logic [2:0] CLS_UTF8_NOBOM  = 3'd3;
  localparam logic [2:0] CLS_UTF16LE_BOM = 3'd4;
  localparam logic [2:0] CLS_UTF16BE_BOM = 3'd5;

  localparam logic [1:0] BOM_LEN_NONE  = 2'd0;
  localparam logic [1:0] BOM_LEN_UTF16 = 2'd2;
  localparam logic [1:0] BOM_LEN_UTF8  = 2'd3;

  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;

  localparam logic [7:0] ASCII_MAX = 8'd127;
  localparam logic [7:0] CONT_MAX  = 8'd191;
  localparam logic [7:0] LEAD2_MIN = 8'd194;
  localparam logic [7:0] LEAD2_MAX = 8'd223;
  localparam logic [7:0] LEAD3_MIN = 8'd224;
  localparam logic [7:0] LEAD3_MAX = 8'd239;
  localparam logic [7:0] LEAD4_MIN = 8'd240;
  localparam logic [7:0] LEAD4_MAX = 8'd244;

  localparam logic [1:0] SEEN_MAX = 2'd3;

endpackage

### rtl/core/ted_scan.sv
module ted_scan
  import ted_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  ted_in_t  item,
  input  logic     null_is_binary,
  output ted_out_t verdict
);

  logic [7:0] lead_r [3];
  logic [7:0] lead_nxt [3];
  logic [1:0] seen_r, seen_nxt;
  logic [1:0] owed_r, owed_nxt;
  logic       invalid_r, invalid_nxt;
  logic       non_ascii_r, non_ascii_nxt;
  logic [7:0] b;

  assign b = item.data_byte;

  always_comb begin
    lead_nxt = lead_r;
    unique case (seen_r)
      2'd0: lead_nxt[0] = b;
      2'd1: lead_nxt[1] = b;
      2'd2: lead_nxt[2] = b;
      default: lead_nxt = lead_r;
    endcase
    seen_nxt = (seen_r == SEEN_MAX) ? SEEN_MAX : seen_r + 2'd1;
  end

  always_comb begin
    owed_nxt      = owed_r;
    invalid_nxt   = invalid_r;
    non_ascii_nxt = non_ascii_r;
    if (!invalid_r) begin
      if (owed_r != 2'd0) begin
        non_ascii_nxt = 1'b1;
        if (b < 8'd128 || b > CONT_MAX) begin
          invalid_nxt = 1'b1;
        end else begin
          owed_nxt = owed_r - 2'd1;
        end
      end else begin
        priority if (b == 8'd0 && null_is_binary) begin
          invalid_nxt = 1'b1;
        end else if (b <= ASCII_MAX) begin
          owed_nxt = 2'd0;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          owed_nxt = 2'd1;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          owed_nxt = 2'd2;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          owed_nxt = 2'd3;
        end else begin
          invalid_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    priority if (seen_nxt >= 2'd2 && lead_nxt[0] == BOM_FF && lead_nxt[1] == BOM_FE) begin
      verdict = '{encoding_class: CLS_UTF16LE_BOM, bom_length: BOM_LEN_UTF16};
    end else if (seen_nxt >= 2'd2 && lead_nxt[0] == BOM_FE && lead_nxt[1] == BOM_FF) begin
      verdict = '{encoding_class: CLS_UTF16BE_BOM, bom_length: BOM_LEN_UTF16};
    end else if (seen_nxt == SEEN_MAX && lead_nxt[0] == BOM_EF &&
                 lead_nxt[1] == BOM_BB && lead_nxt[2] == BOM_BF) begin
      verdict = '{encoding_class: CLS_UTF8_BOM, bom_length: BOM_LEN_UTF8};
    end else if (invalid_nxt) begin
      verdict = '{encoding_class: CLS_NONE, bom_length: BOM_LEN_NONE};
    end else if (non_ascii_nxt) begin
      verdict = '{encoding_class: CLS_UTF8_NOBOM, bom_length: BOM_LEN_NONE};
    end else begin
      verdict = '{encoding_class: CLS_ASCII, bom_length: BOM_LEN_NONE};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 2'd0;
      owed_r      <= 2'd0;
      invalid_r   <= 1'b0;
      non_ascii_r <= 1'b0;
    end else if (fire) begin
      if (item.last_byte) begin
        seen_r      <= 2'd0;
        owed_r      <= 2'd0;
        invalid_r   <= 1'b0;
        non_ascii_r <= 1'b0;
      end else begin
        seen_r      <= seen_nxt;
        owed_r      <= owed_nxt;
        invalid_r   <= invalid_nxt;
        non_ascii_r <= non_ascii_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lead_r <= lead_nxt;
    end
  end

endmodule

### rtl/core/text_encoding_detector.sv
// Text encoding detector.
// The input channel (in_valid, in_ready, in_data) carries one byte of a buffer per
// transaction; last_byte marks the final byte. Only the final byte produces a
// transaction on the output channel (out_valid, out_ready, out_data), holding the
// encoding class and the byte order mark length for the whole buffer.
// A byte is held in an input register while the scan logic updates the per-buffer
// state; the verdict is then loaded into an output register. The verdict appears on
// out_valid when it is loaded there, as the final byte leaves the input register.
// Throughput is one byte per cycle, set by the per-byte state update in the scan logic,
// while no final byte waits. A stalled receiver holds the output register; other bytes
// keep flowing, and a final byte waits in the input register until the output is free.
// Reset (rst_n low, synchronous) empties both registers, clears the buffer state and
// sets null_is_binary to 1. cfg_we writes cfg_wdata into null_is_binary at once; it
// is meant to be written only while no buffer is in flight.
module text_encoding_detector
  import ted_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ted_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ted_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic     in_vld_r;
  ted_in_t  in_item_r;
  logic     out_vld_r;
  ted_out_t out_item_r;
  logic     null_is_binary_r;
  logic     out_free;
  logic     fire;
  ted_out_t verdict;

  assign out_free  = !out_vld_r || out_ready;
  assign fire      = in_vld_r && (!in_item_r.last_byte || out_free);
  assign in_ready  = !in_vld_r || fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_is_binary_r <= 1'b1;
    end else if (cfg_we) begin
      null_is_binary_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  ted_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .item           (in_item_r),
    .null_is_binary (null_is_binary_r),
    .verdict        (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && in_item_r.last_byte) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item_r.last_byte) begin
      out_item_r <= verdict;
    end
  end

endmodule

### rtl/core/ted_checker.sv
`include "assert_macros.svh"

module ted_checker
  import ted_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input ted_out_t out_data
);

  logic out_stall;
  logic utf8_len;
  logic utf8_cls;
  logic utf16_len;
  logic utf16_cls;

  assign out_stall = out_valid && !out_ready;
  assign utf8_len  = (out_data.bom_length == BOM_LEN_UTF8);
  assign utf8_cls  = (out_data.encoding_class == CLS_UTF8_BOM);
  assign utf16_len = (out_data.bom_length == BOM_LEN_UTF16);
  assign utf16_cls = (out_data.encoding_class == CLS_UTF16LE_BOM) ||
                     (out_data.encoding_class == CLS_UTF16BE_BOM);

  `TED_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "Output valid right after reset.")
  `TED_ASSERT(a_hold, out_stall |=> out_valid && $stable(out_data), "Held output changed.")
  `TED_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "Input stalled with output empty.")
  `TED_ASSERT(a_bom_utf8, out_valid |-> (utf8_len == utf8_cls), "UTF-8 BOM fields disagree.")
  `TED_ASSERT(a_bom_utf16, out_valid |-> (utf16_len == utf16_cls), "UTF-16 BOM fields disagree.")

endmodule

bind text_encoding_detector ted_checker u_ted_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/sv/tb_text_encoding_detector.sv
`timescale 1ns / 100ps

module tb_text_encoding_detector;
  import ted_pkg::*;

  localparam int PHASE_ITEMS  = 250;
  localparam int NUM_PHASES   = 5;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 40;
  localparam int DIR_ROWS     = 25;

  localparam logic [7:0] NUL_BYTE = 8'h00;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC, RX_HOLD} rx_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       typed;
    ted_out_t   verdict;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ted_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ted_out_t out_data;
  logic     cfg_we;
  logic     cfg_wdata;

  logic [7:0] lead_bytes [3];
  logic [1:0] seen_cnt;
  logic [1:0] owed;
  bit         bad_seen;
  bit         wide_seen;
  bit         null_bin_cfg;

  ted_out_t   verdict_q [$];
  ted_out_t   verdict_head;
  logic [7:0] pending_bytes [$];
  int         burst_left;
  int         error_count = 0;
  int         cycle_count = 0;
  bit         hold_pending = 1'b0;

  // Rows with a typed verdict are checked against that value; the rest use the predictor.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{BOM_FF, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{BOM_FE, 1'b1, 1'b1, '{CLS_UTF16LE_BOM, BOM_LEN_UTF16}},
    '{BOM_FE, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{BOM_FF, 1'b1, 1'b1, '{CLS_UTF16BE_BOM, BOM_LEN_UTF16}},
    '{BOM_EF, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{BOM_BB, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{BOM_BF, 1'b1, 1'b1, '{CLS_UTF8_BOM, BOM_LEN_UTF8}},
    '{NUL_BYTE, 1'b1, 1'b1, '{CLS_NONE, BOM_LEN_NONE}},
    '{8'h7F, 1'b1, 1'b1, '{CLS_ASCII, BOM_LEN_NONE}},
    '{8'hC2, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{8'h80, 1'b1, 1'b1, '{CLS_UTF8_NOBOM, BOM_LEN_NONE}},
    '{8'hE0, 1'b1, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{8'hF4, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{8'hBF, 1'b1, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{8'hC2, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{NUL_BYTE, 1'b1, 1'b1, '{CLS_NONE, BOM_LEN_NONE}},
    '{8'h80, 1'b1, 1'b1, '{CLS_NONE, BOM_LEN_NONE}},
    '{BOM_FF, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{BOM_FE, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{NUL_BYTE, 1'b1, 1'b1, '{CLS_UTF16LE_BOM, BOM_LEN_UTF16}},
    '{8'hC0, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{8'h41, 1'b1, 1'b1, '{CLS_NONE, BOM_LEN_NONE}},
    '{8'hF5, 1'b1, 1'b1, '{CLS_NONE, BOM_LEN_NONE}},
    '{BOM_EF, 1'b0, 1'b0, '{CLS_NONE, BOM_LEN_NONE}},
    '{BOM_BB, 1'b1, 1'b0, '{CLS_NONE, BOM_LEN_NONE}}
  };

  text_encoding_detector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic clear_scan();
    lead_bytes[0] = '0;
    lead_bytes[1] = '0;
    lead_bytes[2] = '0;
    seen_cnt = '0;
    owed = '0;
    bad_seen = 1'b0;
    wide_seen = 1'b0;
  endtask

  task automatic scan_byte(input ted_in_t item, output bit done, output ted_out_t verdict);
    logic [7:0] b;
    b = item.data_byte;
    done = 1'b0;
    verdict = '0;
    if (seen_cnt < SEEN_MAX) begin
      lead_bytes[seen_cnt] = b;
      seen_cnt = seen_cnt + 2'd1;
    end
    if (!bad_seen) begin
      if (owed != 2'd0) begin
        wide_seen = 1'b1;
        if (b <= ASCII_MAX || b > CONT_MAX) begin
          bad_seen = 1'b1;
        end else begin
          owed = owed - 2'd1;
        end
      end else if (b == NUL_BYTE && null_bin_cfg) begin
        bad_seen = 1'b1;
      end else if (b <= ASCII_MAX) begin
        owed = 2'd0;
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        owed = 2'd1;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        owed = 2'd2;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        owed = 2'd3;
      end else begin
        bad_seen = 1'b1;
      end
    end
    if (item.last_byte) begin
      done = 1'b1;
      if (seen_cnt >= 2'd2 && lead_bytes[0] == BOM_FF && lead_bytes[1] == BOM_FE) begin
        verdict = '{CLS_UTF16LE_BOM, BOM_LEN_UTF16};
      end else if (seen_cnt >= 2'd2 && lead_bytes[0] == BOM_FE && lead_bytes[1] == BOM_FF) begin
        verdict = '{CLS_UTF16BE_BOM, BOM_LEN_UTF16};
      end else if (seen_cnt == SEEN_MAX && lead_bytes[0] == BOM_EF &&
                   lead_bytes[1] == BOM_BB && lead_bytes[2] == BOM_BF) begin
        verdict = '{CLS_UTF8_BOM, BOM_LEN_UTF8};
      end else if (bad_seen) begin
        verdict = '{CLS_NONE, BOM_LEN_NONE};
      end else if (wide_seen) begin
        verdict = '{CLS_UTF8_NOBOM, BOM_LEN_NONE};
      end else begin
        verdict = '{CLS_ASCII, BOM_LEN_NONE};
      end
      clear_scan();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s, got %0d, expected %0d", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input ted_out_t typed_verdict);
    ted_in_t  item;
    bit       done;
    ted_out_t verdict;
    item.data_byte = b;
    item.last_byte = last;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    scan_byte(item, done, verdict);
    if (done) begin
      verdict_q.push_back(typed ? typed_verdict : verdict);
    end
    @(negedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic make_buffer();
    int target;
    int pick;
    int conts;
    bit cut;
    pending_bytes.delete();
    cut = 1'b0;
    case ($urandom_range(0, 11))
      0: begin
        pending_bytes.push_back(BOM_FF);
        pending_bytes.push_back(BOM_FE);
      end
      1: begin
        pending_bytes.push_back(BOM_FE);
        pending_bytes.push_back(BOM_FF);
      end
      2: begin
        pending_bytes.push_back(BOM_EF);
        pending_bytes.push_back(BOM_BB);
        pending_bytes.push_back(BOM_BF);
      end
      3: begin
        pending_bytes.push_back(BOM_EF);
        if ($urandom_range(0, 1) != 0) pending_bytes.push_back(BOM_BB);
      end
      4: begin
        pending_bytes.push_back(($urandom_range(0, 1) != 0) ? BOM_FF : BOM_FE);
      end
      default: ;
    endcase
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
    while (!cut && pending_bytes.size() < target) begin
      pick = $urandom_range(0, 19);
      conts = 0;
      if (pick <= 8) begin
        pending_bytes.push_back(8'($urandom_range(1, 127)));
      end else if (pick == 9) begin
        pending_bytes.push_back(NUL_BYTE);
      end else if (pick <= 11) begin
        pending_bytes.push_back(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
        conts = 1;
      end else if (pick <= 13) begin
        pending_bytes.push_back(8'($urandom_range(LEAD3_MIN, LEAD3_MAX)));
        conts = 2;
      end else if (pick == 14) begin
        pending_bytes.push_back(8'($urandom_range(LEAD4_MIN, LEAD4_MAX)));
        conts = 3;
      end else if (pick == 15) begin
        pending_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 16) begin
        pending_bytes.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(128, 193))
                                                           : 8'($urandom_range(245, 255)));
      end else if (pick == 17) begin
        pending_bytes.push_back(8'($urandom_range(LEAD3_MIN, LEAD4_MAX)));
        conts = $urandom_range(0, 2);
        cut = 1'b1;
      end else if (pick == 18) begin
        pending_bytes.push_back(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
        pending_bytes.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 127))
                                                           : 8'($urandom_range(192, 255)));
      end else begin
        pending_bytes.push_back(8'($urandom_range(128, 191)));
      end
      repeat (conts) pending_bytes.push_back(8'($urandom_range(128, 191)));
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_null_binary(input logic value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    null_bin_cfg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with none pending", int'(out_data.encoding_class), 0);
      end else begin
        verdict_head = verdict_q.pop_front();
        if (out_data.encoding_class !== verdict_head.encoding_class) begin
          report_mismatch("encoding_class", int'(out_data.encoding_class),
                          int'(verdict_head.encoding_class));
        end
        if (out_data.bom_length !== verdict_head.bom_length) begin
          report_mismatch("bom_length", int'(out_data.bom_length),
                          int'(verdict_head.bom_length));
        end
      end
    end
  end

  initial begin : receiver
    rx_mode_t mode;
    int span;
    out_ready = 1'b0;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        mode = RX_HOLD;
        span = HOLD_CYCLES;
      end else begin
        mode = rx_mode_t'($urandom_range(RX_ALWAYS, RX_PERIODIC));
        span = $urandom_range(10, 150);
      end
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
          RX_PERIODIC: out_ready <= ((k % 6) >= 4);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin : stimulus
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    null_bin_cfg = 1'b1;
    burst_left = 0;
    clear_scan();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      pace();
      send_byte(dir_rows[r].data_byte, dir_rows[r].last_byte, dir_rows[r].typed,
                dir_rows[r].verdict);
    end
    quiesce();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_null_binary((phase % 2) != 0);
      if (phase == 1 || phase == 3) hold_pending = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        make_buffer();
        foreach (pending_bytes[i]) begin
          pace();
          send_byte(pending_bytes[i], i == pending_bytes.size() - 1, 1'b0, '0);
          sent++;
        end
      end
      quiesce();
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ted_pkg.sv
rtl/core/ted_scan.sv
rtl/core/text_encoding_detector.sv
rtl/core/ted_checker.sv
tb/sv/tb_text_encoding_detector.sv
